### src/czpa_pkg.sv
// Package for the zero-padded 2-D convolution accumulator.
// Holds sizes, command and register codes, state type, shared structs and clamp functions.
// Depends on nothing.
package czpa_pkg;

    localparam int IMG_DIM    = 64;
    localparam int KER_DIM    = 8;
    localparam int RC_W       = $clog2(IMG_DIM);
    localparam int K_W        = $clog2(KER_DIM);
    localparam int IMG_AW     = 2 * RC_W;
    localparam int KER_AW     = 2 * K_W;
    localparam int DIM_W      = 7;
    localparam int KDIM_W     = 4;
    localparam int PAD_W      = 8;
    localparam int POS_W      = 9;
    localparam int SMP_W      = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 40;
    localparam int ACC_W      = 48;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LD_IMG = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LD_WT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ACCUM  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KER_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KER_W = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_H = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_W = 3'd6;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_TAP, S_DRAIN, S_ACC_RD, S_ACC_WR, S_RD, S_RD2
    } t_state;

    typedef struct packed {
        logic                     mode;
        logic [DIM_W-1:0]         ih;
        logic [DIM_W-1:0]         iw;
        logic [KDIM_W-1:0]        kh;
        logic [KDIM_W-1:0]        kw;
        logic [DIM_W-1:0]         oh;
        logic [DIM_W-1:0]         ow;
        logic signed [PAD_W-1:0]  ph;
        logic signed [PAD_W-1:0]  pw;
    } t_dims;

    typedef struct packed {
        logic              tap_vld;
        logic [RC_W-1:0]   r;
        logic [RC_W-1:0]   c;
        logic [K_W-1:0]    kr;
        logic [K_W-1:0]    kc;
        logic              clr_we;
        logic [IMG_AW-1:0] clr_addr;
        logic              acc_wr;
        logic              rd_req;
        logic              out_load;
    } t_ctrl;

    typedef struct packed {
        logic out_free;
    } t_stat;

    function automatic logic [DIM_W-1:0] clamp_img(logic [DIM_W-1:0] v);
        if (v == '0) return DIM_W'(1);
        if (v > DIM_W'(IMG_DIM)) return DIM_W'(IMG_DIM);
        return v;
    endfunction

    function automatic logic [KDIM_W-1:0] clamp_ker(logic [KDIM_W-1:0] v);
        if (v == '0) return KDIM_W'(1);
        if (v > KDIM_W'(KER_DIM)) return KDIM_W'(KER_DIM);
        return v;
    endfunction

endpackage

### src/czpa_in_if.sv
// Input channel interface: command transactions with valid and ready.
// Depends on czpa_pkg.
interface czpa_in_if import czpa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [RC_W-1:0]         row;
    logic [RC_W-1:0]         col;
    logic signed [SMP_W-1:0] value;

    modport source (output valid, cmd, row, col, value, input ready);
    modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

### src/czpa_out_if.sv
// Output channel interface: read result transactions with valid and ready.
// Depends on czpa_pkg.
interface czpa_out_if import czpa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] out_value;
    logic                    saturated;

    modport source (output valid, out_value, saturated, input ready);
    modport sink   (input valid, out_value, saturated, output ready);
endinterface

### src/czpa_cfg.sv
// Configuration registers with clamped dimensions and padding offsets.
// Depends on czpa_pkg.
module czpa_cfg import czpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_dims                 o_dims
);
    logic              r_mode;
    logic [DIM_W-1:0]  r_ih, r_iw, r_oh, r_ow;
    logic [KDIM_W-1:0] r_kh, r_kw;
    logic signed [POS_W-1:0] dh, dw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_ih   <= DIM_W'(1);
            r_iw   <= DIM_W'(1);
            r_kh   <= KDIM_W'(1);
            r_kw   <= KDIM_W'(1);
            r_oh   <= DIM_W'(1);
            r_ow   <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:  r_mode <= i_cfg_data[0];
                CFG_IN_H:  r_ih   <= i_cfg_data;
                CFG_IN_W:  r_iw   <= i_cfg_data;
                CFG_KER_H: r_kh   <= i_cfg_data[KDIM_W-1:0];
                CFG_KER_W: r_kw   <= i_cfg_data[KDIM_W-1:0];
                CFG_OUT_H: r_oh   <= i_cfg_data;
                CFG_OUT_W: r_ow   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_dims.mode = r_mode;
        o_dims.ih   = clamp_img(r_ih);
        o_dims.iw   = clamp_img(r_iw);
        o_dims.kh   = clamp_ker(r_kh);
        o_dims.kw   = clamp_ker(r_kw);
        o_dims.oh   = clamp_img(r_oh);
        o_dims.ow   = clamp_img(r_ow);
        dh = $signed({2'b00, o_dims.oh}) - $signed({2'b00, o_dims.ih})
           + $signed({5'b00000, o_dims.kh}) - POS_W'(1);
        dw = $signed({2'b00, o_dims.ow}) - $signed({2'b00, o_dims.iw})
           + $signed({5'b00000, o_dims.kw}) - POS_W'(1);
        o_dims.ph = PAD_W'(dh >>> 1);
        o_dims.pw = PAD_W'(dw >>> 1);
    end
endmodule

### src/czpa_ctrl.sv
// Controller: sequences clearing sweeps, kernel taps, accumulator updates and reads.
// Depends on czpa_pkg.
module czpa_ctrl import czpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_vld,
    input  logic [CMD_W-1:0] i_in_cmd,
    input  t_dims            i_dims,
    input  t_stat            i_stat,
    output logic             o_in_rdy,
    output t_ctrl            o_ctl
);
    t_state            r_state, n_state;
    logic [IMG_AW-1:0] r_clr, n_clr;
    logic [RC_W-1:0]   r_r, n_r, r_c, n_c;
    logic [K_W-1:0]    r_kr, n_kr, r_kc, n_kc;
    logic              acc_pulse, tap_end, col_end, cell_end;

    assign acc_pulse = i_in_vld && (r_state == S_IDLE);
    assign col_end   = r_kc == K_W'(i_dims.kw - KDIM_W'(1));
    assign tap_end   = col_end && (r_kr == K_W'(i_dims.kh - KDIM_W'(1)));
    assign cell_end  = (r_c == RC_W'(i_dims.ow - DIM_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_r     <= '0;
            r_c     <= '0;
            r_kr    <= '0;
            r_kc    <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_r     <= n_r;
            r_c     <= n_c;
            r_kr    <= n_kr;
            r_kc    <= n_kc;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:    if (&r_clr) n_state = S_IDLE;
            S_IDLE: begin
                if (acc_pulse) begin
                    case (i_in_cmd)
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_ACCUM: n_state = S_TAP;
                        CMD_READ:  n_state = S_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_TAP:    if (tap_end) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_ACC_RD;
            S_ACC_RD: n_state = S_ACC_WR;
            S_ACC_WR: begin
                if (cell_end && (r_r == RC_W'(i_dims.oh - DIM_W'(1)))) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_TAP;
                end
            end
            S_RD:     if (i_stat.out_free) n_state = S_RD2;
            S_RD2:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_clr = r_clr;
        n_r   = r_r;
        n_c   = r_c;
        n_kr  = r_kr;
        n_kc  = r_kc;
        case (r_state)
            S_CLR: n_clr = r_clr + IMG_AW'(1);
            S_IDLE: begin
                n_clr = '0;
                n_r   = '0;
                n_c   = '0;
                n_kr  = '0;
                n_kc  = '0;
            end
            S_TAP: begin
                if (col_end) begin
                    n_kc = '0;
                    n_kr = tap_end ? '0 : r_kr + K_W'(1);
                end else begin
                    n_kc = r_kc + K_W'(1);
                end
            end
            S_ACC_WR: begin
                if (cell_end) begin
                    n_c = '0;
                    n_r = r_r + RC_W'(1);
                end else begin
                    n_c = r_c + RC_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_in_rdy       = (r_state == S_IDLE);
        o_ctl.tap_vld  = (r_state == S_TAP);
        o_ctl.r        = r_r;
        o_ctl.c        = r_c;
        o_ctl.kr       = r_kr;
        o_ctl.kc       = r_kc;
        o_ctl.clr_we   = (r_state == S_CLR);
        o_ctl.clr_addr = r_clr;
        o_ctl.acc_wr   = (r_state == S_ACC_WR);
        o_ctl.rd_req   = (r_state == S_RD);
        o_ctl.out_load = (r_state == S_RD2);
    end
endmodule

### src/czpa_dp.sv
// Datapath: image, weight and accumulator memories, MAC pipeline, result register.
// Depends on czpa_pkg.
module czpa_dp import czpa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [RC_W-1:0]         i_row,
    input  logic [RC_W-1:0]         i_col,
    input  logic signed [SMP_W-1:0] i_value,
    input  t_dims                   i_dims,
    input  t_ctrl                   i_ctl,
    input  logic                    i_out_rdy,
    output t_stat                   o_stat,
    output logic                    o_out_vld,
    output logic signed [ACC_W-1:0] o_out_value,
    output logic                    o_saturated
);
    logic signed [SMP_W-1:0]  img_mem [IMG_DIM*IMG_DIM];
    logic signed [SMP_W-1:0]  wt_mem  [KER_DIM*KER_DIM];
    logic [ACC_W:0]           acc_mem [IMG_DIM*IMG_DIM];

    logic signed [SMP_W-1:0]  r_img_q, r_wt_q;
    logic [ACC_W:0]           r_acc_q;
    logic                     r_p1_vld, r_p1_in, r_p2_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic [RC_W-1:0]          r_rrow, r_rcol;
    logic                     r_out_vld;
    logic signed [ACC_W-1:0]  r_out_value;
    logic                     r_saturated;

    logic signed [POS_W-1:0]  ir, ic;
    logic                     tap_in;
    logic [K_W-1:0]           wr, wc;
    logic [IMG_AW-1:0]        img_raddr, acc_raddr, acc_waddr;
    logic                     acc_we;
    logic [ACC_W:0]           acc_wdata;
    logic signed [ACC_W:0]    upd;
    logic                     ovf, rd_in;

    always_comb begin
        ir = $signed({3'b000, i_ctl.r}) + $signed({6'b000000, i_ctl.kr})
           - $signed({i_dims.ph[PAD_W-1], i_dims.ph});
        ic = $signed({3'b000, i_ctl.c}) + $signed({6'b000000, i_ctl.kc})
           - $signed({i_dims.pw[PAD_W-1], i_dims.pw});
        tap_in = !ir[POS_W-1] && (ir[PAD_W-1:0] < {1'b0, i_dims.ih})
              && !ic[POS_W-1] && (ic[PAD_W-1:0] < {1'b0, i_dims.iw});
        img_raddr = {ir[RC_W-1:0], ic[RC_W-1:0]};
        if (i_dims.mode == 1'b0) begin
            wr = K_W'(i_dims.kh - KDIM_W'(1)) - i_ctl.kr;
            wc = K_W'(i_dims.kw - KDIM_W'(1)) - i_ctl.kc;
        end else begin
            wr = i_ctl.kr;
            wc = i_ctl.kc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (i_cmd == CMD_LD_IMG)) begin
            img_mem[{i_row, i_col}] <= i_value;
        end
        r_img_q <= img_mem[img_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (i_cmd == CMD_LD_WT) && (i_row < RC_W'(KER_DIM))
            && (i_col < RC_W'(KER_DIM))) begin
            wt_mem[{i_row[K_W-1:0], i_col[K_W-1:0]}] <= i_value;
        end
        r_wt_q <= wt_mem[{wr, wc}];
    end

    always_comb begin
        acc_raddr = i_ctl.rd_req ? {r_rrow, r_rcol} : {i_ctl.r, i_ctl.c};
        upd = $signed({r_acc_q[ACC_W-1], r_acc_q[ACC_W-1:0]})
            + $signed({{(ACC_W+1-SUM_W){r_sum[SUM_W-1]}}, r_sum});
        ovf = upd[ACC_W] != upd[ACC_W-1];
        acc_we    = i_ctl.clr_we || i_ctl.acc_wr;
        acc_waddr = i_ctl.clr_we ? i_ctl.clr_addr : {i_ctl.r, i_ctl.c};
        if (i_ctl.clr_we) begin
            acc_wdata = '0;
        end else if (ovf) begin
            acc_wdata = {1'b1, upd[ACC_W], {(ACC_W-1){~upd[ACC_W]}}};
        end else begin
            acc_wdata = {r_acc_q[ACC_W], upd[ACC_W-1:0]};
        end
        rd_in = (r_rrow < RC_W'(i_dims.oh - DIM_W'(1)) || r_rrow == RC_W'(i_dims.oh - DIM_W'(1)))
             && (r_rcol < RC_W'(i_dims.ow - DIM_W'(1)) || r_rcol == RC_W'(i_dims.ow - DIM_W'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        r_acc_q <= acc_mem[acc_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_p1_in ? PROD_W'(r_img_q * r_wt_q) : '0;
        if (i_accept) begin
            r_rrow <= i_row;
            r_rcol <= i_col;
        end
        if (i_ctl.out_load) begin
            r_out_value <= rd_in ? $signed(r_acc_q[ACC_W-1:0]) : '0;
            r_saturated <= rd_in ? r_acc_q[ACC_W] : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p1_in   <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_sum     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_ctl.tap_vld;
            r_p1_in  <= i_ctl.tap_vld && tap_in;
            r_p2_vld <= r_p1_vld;
            if (i_ctl.acc_wr) begin
                r_sum <= '0;
            end else if (r_p2_vld) begin
                r_sum <= r_sum + SUM_W'(r_prod);
            end
            if (i_ctl.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_vld || i_out_rdy;
    assign o_out_vld       = r_out_vld;
    assign o_out_value     = r_out_value;
    assign o_saturated     = r_saturated;
endmodule

### src/conv2d_zero_pad_accumulate_core.sv
// Top level of the zero-padded 2-D convolution accumulator.
// Depends on czpa_pkg, czpa_in_if, czpa_out_if, czpa_cfg, czpa_ctrl and czpa_dp.
//
// Channel   Direction  Payload                      Handshake
// i_in_ch   in         cmd, row, col, value         valid / ready
// o_out_ch  out        out_value, saturated         valid / ready
// i_cfg_*   in         register index, data         write enable only
//
// Loads and unused commands are taken in the idle state; a read passes through S_RD,
// where it waits for a free output register, then S_RD2, which loads the result.
// A clear writes zero to every accumulator entry, one entry per cycle, as does the sweep
// after reset, before ready rises. An accumulate runs the kernel taps of each output
// element through the single MAC unit, with one accumulator update per output element.
// A read result waits in an output register; other transactions are taken meanwhile,
// and a further read waits in the controller until that register drains.
module conv2d_zero_pad_accumulate_core import czpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    czpa_in_if.sink               i_in_ch,
    czpa_out_if.source            o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_dims dims;
    t_ctrl ctl;
    t_stat stat;
    logic  in_rdy;

    assign i_in_ch.ready = in_rdy;

    czpa_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_dims     (dims)
    );

    czpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_vld (i_in_ch.valid),
        .i_in_cmd (i_in_ch.cmd),
        .i_dims   (dims),
        .i_stat   (stat),
        .o_in_rdy (in_rdy),
        .o_ctl    (ctl)
    );

    czpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_in_ch.valid && in_rdy),
        .i_cmd       (i_in_ch.cmd),
        .i_row       (i_in_ch.row),
        .i_col       (i_in_ch.col),
        .i_value     (i_in_ch.value),
        .i_dims      (dims),
        .i_ctl       (ctl),
        .i_out_rdy   (o_out_ch.ready),
        .o_stat      (stat),
        .o_out_vld   (o_out_ch.valid),
        .o_out_value (o_out_ch.out_value),
        .o_saturated (o_out_ch.saturated)
    );
endmodule
